FILE: design/conv2d_sigmoid_engine_unit_defines.svh
// Assertion macros for the conv2d sigmoid engine unit.
// Taken in by the port checker; depends on nothing else.
`ifndef CONV2D_SIGMOID_ENGINE_UNIT_DEFINES_SVH
`define CONV2D_SIGMOID_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define C2S_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define C2S_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/c2s_pkg.sv
// Shared constants, tables and types of the conv2d sigmoid engine.
// Used by the top level, the sigmoid unit and the port checker.
`default_nettype none

package c2s_pkg;

	// Sizing of the stores.
	localparam int MAX_KERNEL   = 7;
	localparam int MAX_FILTERS  = 16;
	localparam int MAX_CHANNELS = 4;
	localparam int MAX_WIDTH    = 256;

	localparam int TAPS         = MAX_KERNEL * MAX_KERNEL;
	localparam int WEIGHT_DEPTH = MAX_CHANNELS * MAX_FILTERS * TAPS;
	localparam int LINE_DEPTH   = MAX_KERNEL * MAX_WIDTH;
	localparam int WEIGHT_AW    = $clog2(WEIGHT_DEPTH);
	localparam int LINE_AW      = $clog2(LINE_DEPTH);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WCNT_W = COL_W + 1;
	localparam int ROW_W  = 8;
	localparam int HCNT_W = 9;
	localparam int KW     = $clog2(MAX_KERNEL + 1);
	localparam int SLOT_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int KK_W   = $clog2(TAPS + 1);
	localparam int FIDX_W = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
	localparam int FCNT_W = $clog2(MAX_FILTERS + 1);
	localparam int CCNT_W = $clog2(MAX_CHANNELS + 1);

	// Accumulator: one product per tap plus the bias term.
	localparam int ACC_W = 32 + $clog2(TAPS + 1);
	localparam int Q_W   = ACC_W + 1 - 14;
	localparam int SAT_W = (Q_W > 33) ? Q_W : 33;
	localparam logic signed [SAT_W-1:0] PRE_MAX = SAT_W'(32'sh7FFF_FFFF);
	localparam logic signed [SAT_W-1:0] PRE_MIN = SAT_W'(32'sh8000_0000);

	// APB port.
	localparam int PADDR_W = 5;

	// Register indexes.
	localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd1;
	localparam logic [2:0] REG_KERNEL_SIZE     = 3'd2;
	localparam logic [2:0] REG_STEP_SIZE       = 3'd3;
	localparam logic [2:0] REG_FILTERS_IN_USE  = 3'd4;
	localparam logic [2:0] REG_CHANNELS_IN_USE = 3'd5;

	// Item modes.
	localparam logic [1:0] MODE_WEIGHT = 2'd0;
	localparam logic [1:0] MODE_BIAS   = 2'd1;
	localparam logic [1:0] MODE_PIXEL  = 2'd2;

	// ceil(2^16 / s), so that (v * recip) >> 16 is v / s for narrow v.
	localparam logic [16:0] STRIDE_RECIP [8] = '{
		17'd65536, 17'd65536, 17'd32768, 17'd21846,
		17'd16384, 17'd13108, 17'd10923, 17'd9363
	};

	// 2^(-k/16) in Q16 for k = 0..16.
	localparam logic [16:0] EXP2_TAB [17] = '{
		17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
		17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
		17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
	};

	// Request to and response from the sigmoid unit.
	typedef struct packed {
		logic        start;
		logic [31:0] x;
	} sig_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] y;
	} sig_rsp_t;

endpackage

`default_nettype wire

FILE: design/c2s_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing else.
`default_nettype none

module c2s_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: design/c2s_sigmoid.sv
// Iterative logistic sigmoid: exp(-|x|) by table interpolation, then a
// bit-serial divide. Depends on c2s_pkg.
`default_nettype none

module c2s_sigmoid (
	input  logic              clk,
	input  logic              arst_n,
	input  c2s_pkg::sig_req_t req,
	output c2s_pkg::sig_rsp_t rsp
);

	typedef enum logic [5:0] {
		SG_IDLE = 6'b000001,
		SG_MUL  = 6'b000010,
		SG_INT  = 6'b000100,
		SG_EXP  = 6'b001000,
		SG_DIV  = 6'b010000,
		SG_DONE = 6'b100000
	} sg_state_t;

	sg_state_t   state_q;
	logic        pos_q;
	logic [31:0] a_q;
	logic [32:0] t_q;
	logic [23:0] prod_q;
	logic [17:0] den_q;
	logic [17:0] rem_q;
	logic [16:0] shreg_q;
	logic [16:0] quo_q;
	logic [4:0]  cnt_q;

	logic [48:0] t_full;
	logic [11:0] diff;
	logic [16:0] v;
	logic [16:0] e;
	logic [17:0] den;
	logic [32:0] dvd;
	logic [18:0] rem_sh;

	// Datapath of the individual steps.
	always_comb begin
		t_full = 49'(a_q) * 49'(17'd94548);
		diff   = 12'(c2s_pkg::EXP2_TAB[{1'b0, t_q[15:12]}]
			- c2s_pkg::EXP2_TAB[{1'b0, t_q[15:12]} + 5'd1]);
		v      = c2s_pkg::EXP2_TAB[{1'b0, t_q[15:12]}] - 17'(prod_q[23:12]);
		e      = (t_q[32:20] != 13'd0) ? 17'd0 : (v >> t_q[19:16]);
		den    = 18'(e) + 18'd65536;
		dvd    = (pos_q ? 33'h1_0000_0000 : (33'(e) << 16)) + 33'(den >> 1);
		rem_sh = {rem_q, shreg_q[16]};
	end

	// Sequencer and step registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SG_IDLE;
			cnt_q   <= 5'd0;
		end else begin
			unique case (state_q)
				SG_IDLE: begin
					if (req.start) begin
						pos_q   <= ~req.x[31];
						a_q     <= req.x[31] ? (32'd0 - req.x) : req.x;
						state_q <= SG_MUL;
					end
				end
				SG_MUL: begin
					t_q     <= t_full[48:16];
					state_q <= SG_INT;
				end
				SG_INT: begin
					prod_q  <= 24'(diff) * 24'(t_q[11:0]);
					state_q <= SG_EXP;
				end
				SG_EXP: begin
					den_q   <= den;
					rem_q   <= 18'(dvd[32:17]);
					shreg_q <= dvd[16:0];
					quo_q   <= 17'd0;
					cnt_q   <= 5'd16;
					state_q <= SG_DIV;
				end
				SG_DIV: begin
					// One restoring quotient bit per cycle.
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q <= 18'(rem_sh - {1'b0, den_q});
						quo_q <= {quo_q[15:0], 1'b1};
					end else begin
						rem_q <= rem_sh[17:0];
						quo_q <= {quo_q[15:0], 1'b0};
					end
					shreg_q <= {shreg_q[15:0], 1'b0};
					if (cnt_q == 5'd0) begin
						state_q <= SG_DONE;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				SG_DONE: begin
					state_q <= SG_IDLE;
				end
				default: begin
					state_q <= SG_IDLE;
				end
			endcase
		end
	end

	// The quotient saturates at the largest Q0.16 value.
	assign rsp.done = (state_q == SG_DONE);
	assign rsp.y    = quo_q[16] ? 16'hFFFF : quo_q[15:0];

endmodule

`default_nettype wire

FILE: design/conv2d_sigmoid_engine_unit.sv
// Top level of the conv2d sigmoid engine: APB registers, stores, sequencer
// and shared multiply-accumulate. Depends on c2s_pkg, c2s_ram, c2s_sigmoid.
`default_nettype none

// Per-channel valid 2-D convolution with bias and sigmoid. Weight and bias
// loads leave the block ready for the next item. A pixel that completes no
// window passes through transfer and window decode and returns to idle. A
// pixel that completes a window then goes, for each active filter, through
// the k*k taps, the drain, the sigmoid divide and the output, one result at
// a time; no new item is taken until the last result is transferred, and a
// result that waits at the output holds the block. The single multiply-
// accumulate (one tap per cycle) and the bit-serial divide in the sigmoid
// unit do this work. The weight and line stores hold whatever was last
// written; nothing is cleared after reset.
module conv2d_sigmoid_engine_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [c2s_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   mode,
	input  logic [1:0]                   channel,
	input  logic [3:0]                   filter_index,
	input  logic [5:0]                   tap_index,
	input  logic signed [15:0]           sample,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   out_channel,
	output logic [3:0]                   out_filter,
	output logic [7:0]                   out_row,
	output logic [7:0]                   out_col,
	output logic signed [31:0]           pre_activation,
	output logic [15:0]                  activated,
	output logic                         last
);

	localparam int ROW_W  = c2s_pkg::ROW_W;
	localparam int COL_W  = c2s_pkg::COL_W;
	localparam int ACC_W  = c2s_pkg::ACC_W;
	localparam int SAT_W  = c2s_pkg::SAT_W;
	localparam int SLOT_W = c2s_pkg::SLOT_W;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_DIV    = 10'b0000000010,
		ST_CHECK  = 10'b0000000100,
		ST_FSTART = 10'b0000001000,
		ST_MAC    = 10'b0000010000,
		ST_DRAIN  = 10'b0000100000,
		ST_FIN    = 10'b0001000000,
		ST_SGO    = 10'b0010000000,
		ST_SWAIT  = 10'b0100000000,
		ST_OUT    = 10'b1000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [8:0] cfg_width_q;
	logic [8:0] cfg_height_q;
	logic [2:0] cfg_kernel_q;
	logic [2:0] cfg_stride_q;
	logic [4:0] cfg_filters_q;
	logic [2:0] cfg_channels_q;
	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[c2s_pkg::PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q    <= 9'd28;
			cfg_height_q   <= 9'd28;
			cfg_kernel_q   <= 3'd3;
			cfg_stride_q   <= 3'd1;
			cfg_filters_q  <= 5'd1;
			cfg_channels_q <= 3'd1;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				c2s_pkg::REG_IMAGE_WIDTH:     cfg_width_q    <= pwdata[8:0];
				c2s_pkg::REG_IMAGE_HEIGHT:    cfg_height_q   <= pwdata[8:0];
				c2s_pkg::REG_KERNEL_SIZE:     cfg_kernel_q   <= pwdata[2:0];
				c2s_pkg::REG_STEP_SIZE:       cfg_stride_q   <= pwdata[2:0];
				c2s_pkg::REG_FILTERS_IN_USE:  cfg_filters_q  <= pwdata[4:0];
				c2s_pkg::REG_CHANNELS_IN_USE: cfg_channels_q <= pwdata[2:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (cfg_idx)
			c2s_pkg::REG_IMAGE_WIDTH:     prdata = 32'(cfg_width_q);
			c2s_pkg::REG_IMAGE_HEIGHT:    prdata = 32'(cfg_height_q);
			c2s_pkg::REG_KERNEL_SIZE:     prdata = 32'(cfg_kernel_q);
			c2s_pkg::REG_STEP_SIZE:       prdata = 32'(cfg_stride_q);
			c2s_pkg::REG_FILTERS_IN_USE:  prdata = 32'(cfg_filters_q);
			c2s_pkg::REG_CHANNELS_IN_USE: prdata = 32'(cfg_channels_q);
			default:                      prdata = 32'd0;
		endcase
	end

	// Register values clamped to their usable ranges.
	logic [c2s_pkg::WCNT_W-1:0] width_eff;
	logic [c2s_pkg::HCNT_W-1:0] height_eff;
	logic [c2s_pkg::KW-1:0]     k_eff;
	logic [2:0]                 stride_eff;
	logic [c2s_pkg::FCNT_W-1:0] nf_eff;
	logic [c2s_pkg::CCNT_W-1:0] nc_eff;

	always_comb begin
		if (cfg_width_q == 9'd0) begin
			width_eff = c2s_pkg::WCNT_W'(1);
		end else if (int'(cfg_width_q) > c2s_pkg::MAX_WIDTH) begin
			width_eff = c2s_pkg::WCNT_W'(c2s_pkg::MAX_WIDTH);
		end else begin
			width_eff = c2s_pkg::WCNT_W'(cfg_width_q);
		end
		if (cfg_height_q == 9'd0) begin
			height_eff = c2s_pkg::HCNT_W'(1);
		end else if (int'(cfg_height_q) > 256) begin
			height_eff = c2s_pkg::HCNT_W'(256);
		end else begin
			height_eff = c2s_pkg::HCNT_W'(cfg_height_q);
		end
		if (cfg_kernel_q == 3'd0) begin
			k_eff = c2s_pkg::KW'(1);
		end else if (int'(cfg_kernel_q) > c2s_pkg::MAX_KERNEL) begin
			k_eff = c2s_pkg::KW'(c2s_pkg::MAX_KERNEL);
		end else begin
			k_eff = c2s_pkg::KW'(cfg_kernel_q);
		end
		stride_eff = (cfg_stride_q == 3'd0) ? 3'd1 : cfg_stride_q;
		if (cfg_filters_q == 5'd0) begin
			nf_eff = c2s_pkg::FCNT_W'(1);
		end else if (int'(cfg_filters_q) > c2s_pkg::MAX_FILTERS) begin
			nf_eff = c2s_pkg::FCNT_W'(c2s_pkg::MAX_FILTERS);
		end else begin
			nf_eff = c2s_pkg::FCNT_W'(cfg_filters_q);
		end
		if (cfg_channels_q == 3'd0) begin
			nc_eff = c2s_pkg::CCNT_W'(1);
		end else if (int'(cfg_channels_q) > c2s_pkg::MAX_CHANNELS) begin
			nc_eff = c2s_pkg::CCNT_W'(c2s_pkg::MAX_CHANNELS);
		end else begin
			nc_eff = c2s_pkg::CCNT_W'(cfg_channels_q);
		end
	end

	// Input transfer and store writes.
	logic in_xfer;
	logic w_we;
	logic l_we;
	logic [c2s_pkg::WEIGHT_AW-1:0] w_waddr;
	logic [c2s_pkg::WEIGHT_AW-1:0] w_raddr;
	logic [c2s_pkg::LINE_AW-1:0]   l_waddr;
	logic [c2s_pkg::LINE_AW-1:0]   l_raddr;
	logic [15:0] w_rdata;
	logic [15:0] l_rdata;

	logic [ROW_W-1:0]  pos_row_q;
	logic [COL_W-1:0]  pos_col_q;
	logic [SLOT_W-1:0] pos_slot_q;
	logic [15:0]       bias_q [c2s_pkg::MAX_FILTERS];

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid & in_ready;

	assign w_we = in_xfer && (mode == c2s_pkg::MODE_WEIGHT)
		&& (int'(channel) < c2s_pkg::MAX_CHANNELS)
		&& (int'(filter_index) < c2s_pkg::MAX_FILTERS)
		&& (int'(tap_index) < c2s_pkg::TAPS);
	assign w_waddr = c2s_pkg::WEIGHT_AW'((int'(channel) * c2s_pkg::MAX_FILTERS
		+ int'(filter_index)) * c2s_pkg::TAPS + int'(tap_index));
	assign l_we    = in_xfer && (mode == c2s_pkg::MODE_PIXEL);
	assign l_waddr = c2s_pkg::LINE_AW'(int'(pos_slot_q) * c2s_pkg::MAX_WIDTH
		+ int'(pos_col_q));

	c2s_ram #(
		.WIDTH (16),
		.DEPTH (c2s_pkg::WEIGHT_DEPTH)
	) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (sample),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	c2s_ram #(
		.WIDTH (16),
		.DEPTH (c2s_pkg::LINE_DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (sample),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	// Bias registers.
	always_ff @(posedge clk) begin
		if (in_xfer && (mode == c2s_pkg::MODE_BIAS)
				&& (int'(filter_index) < c2s_pkg::MAX_FILTERS)) begin
			bias_q[c2s_pkg::FIDX_W'(filter_index)] <= sample;
		end
	end

	// Raster position; the slot tracks the row modulo the kernel limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_row_q  <= '0;
			pos_col_q  <= '0;
			pos_slot_q <= '0;
		end else if (l_we) begin
			if (int'(pos_col_q) + 1 >= int'(width_eff)) begin
				pos_col_q <= '0;
				if (int'(pos_row_q) + 1 >= int'(height_eff)) begin
					pos_row_q  <= '0;
					pos_slot_q <= '0;
				end else begin
					pos_row_q  <= pos_row_q + ROW_W'(1);
					pos_slot_q <= (int'(pos_slot_q) == c2s_pkg::MAX_KERNEL - 1)
						? '0 : pos_slot_q + SLOT_W'(1);
				end
			end else begin
				pos_col_q <= pos_col_q + COL_W'(1);
			end
		end
	end

	// Window decode: origin, stride quotients and the zero-remainder check.
	logic [ROW_W-1:0]  px_row_q;
	logic [COL_W-1:0]  px_col_q;
	logic [1:0]        px_ch_q;
	logic [SLOT_W-1:0] px_slot_q;
	logic [ROW_W-1:0]  r0_q;
	logic [COL_W-1:0]  c0_q;
	logic [ROW_W-1:0]  qr_q;
	logic [COL_W-1:0]  qc_q;
	logic              win_q;

	logic [16:0]         recip;
	logic [ROW_W+16:0]   qr_prod;
	logic [COL_W+16:0]   qc_prod;
	logic [ROW_W-1:0]    r0;
	logic [COL_W-1:0]    c0;
	logic                win;
	logic                hit;
	logic [SLOT_W:0]     slot_sum;
	logic [SLOT_W-1:0]   slot0;

	always_comb begin
		r0      = ROW_W'(int'(px_row_q) + 1 - int'(k_eff));
		c0      = COL_W'(int'(px_col_q) + 1 - int'(k_eff));
		win     = (int'(px_row_q) + 1 >= int'(k_eff))
			&& (int'(px_col_q) + 1 >= int'(k_eff))
			&& (int'(px_ch_q) < int'(nc_eff));
		recip   = c2s_pkg::STRIDE_RECIP[stride_eff];
		qr_prod = (ROW_W+17)'(r0) * (ROW_W+17)'(recip);
		qc_prod = (COL_W+17)'(c0) * (COL_W+17)'(recip);
		hit     = win_q
			&& (r0_q == ROW_W'(qr_q * ROW_W'(stride_eff)))
			&& (c0_q == COL_W'(qc_q * COL_W'(stride_eff)));
		slot_sum = (SLOT_W+1)'(int'(px_slot_q) + 1 + c2s_pkg::MAX_KERNEL - int'(k_eff));
		if (int'(slot_sum) >= c2s_pkg::MAX_KERNEL) begin
			slot0 = SLOT_W'(int'(slot_sum) - c2s_pkg::MAX_KERNEL);
		end else begin
			slot0 = SLOT_W'(slot_sum);
		end
	end

	// Tap sequencing and multiply-accumulate.
	logic [c2s_pkg::FIDX_W-1:0]    f_q;
	logic [c2s_pkg::WEIGHT_AW-1:0] wbase_q;
	logic [c2s_pkg::TAP_W-1:0]     tap_q;
	logic [c2s_pkg::KK_W-1:0]      kk_q;
	logic [c2s_pkg::KW-1:0]        j_q;
	logic [SLOT_W-1:0]             slot0_q;
	logic [SLOT_W-1:0]             slot_rd_q;
	logic                          rd_v_s1;
	logic                          mul_v_s2;
	logic signed [31:0]            prod_s2;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [31:0]            pre_q;
	logic [15:0]                   act_q;
	logic                          last_f;

	logic signed [ACC_W:0]   rnd_sum;
	logic signed [SAT_W-1:0] q_ext;
	logic signed [31:0]      pre_sat;

	assign w_raddr = wbase_q + c2s_pkg::WEIGHT_AW'(tap_q);
	assign l_raddr = c2s_pkg::LINE_AW'(int'(slot_rd_q) * c2s_pkg::MAX_WIDTH
		+ int'(c0_q) + int'(j_q));
	assign last_f  = (int'(f_q) == int'(nf_eff) - 1);

	// Rounding to Q15.16 and saturation.
	always_comb begin
		rnd_sum = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(8192);
		q_ext   = SAT_W'(rnd_sum >>> 14);
		if (q_ext > c2s_pkg::PRE_MAX) begin
			pre_sat = 32'sh7FFF_FFFF;
		end else if (q_ext < c2s_pkg::PRE_MIN) begin
			pre_sat = 32'sh8000_0000;
		end else begin
			pre_sat = q_ext[31:0];
		end
	end

	// Read data and product pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1  <= 1'b0;
			mul_v_s2 <= 1'b0;
		end else begin
			rd_v_s1  <= (state_q == ST_MAC);
			mul_v_s2 <= rd_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(w_rdata) * $signed(l_rdata);
	end

	// Sigmoid unit.
	c2s_pkg::sig_req_t sig_req;
	c2s_pkg::sig_rsp_t sig_rsp;

	assign sig_req.start = (state_q == ST_SGO);
	assign sig_req.x     = pre_q;

	c2s_sigmoid u_sigmoid (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sig_req),
		.rsp    (sig_rsp)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (l_we) begin
						px_row_q  <= pos_row_q;
						px_col_q  <= pos_col_q;
						px_ch_q   <= channel;
						px_slot_q <= pos_slot_q;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					r0_q    <= r0;
					c0_q    <= c0;
					qr_q    <= qr_prod[ROW_W+15:16];
					qc_q    <= qc_prod[COL_W+15:16];
					win_q   <= win;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					f_q     <= '0;
					wbase_q <= c2s_pkg::WEIGHT_AW'(int'(px_ch_q) * c2s_pkg::MAX_FILTERS
						* c2s_pkg::TAPS);
					kk_q    <= c2s_pkg::KK_W'(int'(k_eff) * int'(k_eff));
					slot0_q <= slot0;
					state_q <= hit ? ST_FSTART : ST_IDLE;
				end
				ST_FSTART: begin
					acc_q     <= {{(ACC_W-31){bias_q[f_q][15]}}, bias_q[f_q], 15'd0};
					tap_q     <= '0;
					j_q       <= '0;
					slot_rd_q <= slot0_q;
					state_q   <= ST_MAC;
				end
				ST_MAC: begin
					// One tap is read per cycle, row-major.
					if (int'(tap_q) == int'(kk_q) - 1) begin
						state_q <= ST_DRAIN;
					end else begin
						tap_q <= tap_q + c2s_pkg::TAP_W'(1);
						if (int'(j_q) == int'(k_eff) - 1) begin
							j_q       <= '0;
							slot_rd_q <= (int'(slot_rd_q) == c2s_pkg::MAX_KERNEL - 1)
								? '0 : slot_rd_q + SLOT_W'(1);
						end else begin
							j_q <= j_q + c2s_pkg::KW'(1);
						end
					end
				end
				ST_DRAIN: begin
					if (!rd_v_s1 && !mul_v_s2) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					pre_q   <= pre_sat;
					state_q <= ST_SGO;
				end
				ST_SGO: begin
					state_q <= ST_SWAIT;
				end
				ST_SWAIT: begin
					if (sig_rsp.done) begin
						act_q   <= sig_rsp.y;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						if (last_f) begin
							state_q <= ST_IDLE;
						end else begin
							f_q     <= f_q + c2s_pkg::FIDX_W'(1);
							wbase_q <= wbase_q + c2s_pkg::WEIGHT_AW'(c2s_pkg::TAPS);
							state_q <= ST_FSTART;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// Accumulate each registered product.
			if (mul_v_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	// Result transfer.
	assign out_valid      = (state_q == ST_OUT);
	assign out_channel    = px_ch_q;
	assign out_filter     = 4'(f_q);
	assign out_row        = 8'(qr_q);
	assign out_col        = 8'(qc_q);
	assign pre_activation = pre_q;
	assign activated      = act_q;
	assign last           = last_f;

endmodule

`default_nettype wire

FILE: design/c2s_checker.sv
// Port-level checker for the conv2d sigmoid engine unit, bound to the top.
// Depends on c2s_pkg and conv2d_sigmoid_engine_unit_defines.svh.
`default_nettype none

`include "conv2d_sigmoid_engine_unit_defines.svh"

module c2s_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         mode,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] pre_activation,
	input logic [15:0]        activated
);

	// One item at a time: no input transfer while a result is pending.
	`C2S_ASSERT_NOW(a_no_input_while_result, clk, arst_n, out_valid, !in_ready, "input ready while a result waits")

	// Loads and ignored items leave the block ready for the next transfer.
	`C2S_ASSERT_NEXT(a_load_keeps_ready, clk, arst_n, in_valid && in_ready && (mode != c2s_pkg::MODE_PIXEL), in_ready, "ready dropped after a load")

	// A non-negative pre-activation gives a sigmoid of at least one half.
	`C2S_ASSERT_NOW(a_sigmoid_upper_half, clk, arst_n, out_valid && !pre_activation[31], activated[15], "sigmoid below one half for non-negative input")

	// A stalled result holds its values.
	`C2S_ASSERT_NEXT(a_result_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(pre_activation) && $stable(activated), "stalled result changed")

endmodule

bind conv2d_sigmoid_engine_unit c2s_checker u_c2s_checker (.*);

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for conv2d_sigmoid_engine_unit: APB setup, stream stimulus,
// and a scoreboard that predicts every convolution and sigmoid result.
// Depends on c2s_pkg and the RTL of the engine only.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 4000000;

	typedef struct {
		logic [1:0]         mode;
		logic [1:0]         ch;
		logic [3:0]         filt;
		logic [5:0]         tap;
		logic signed [15:0] smp;
	} stream_item_t;

	typedef struct packed {
		logic [1:0]         ch;
		logic [3:0]         filt;
		logic [7:0]         row;
		logic [7:0]         col;
		logic signed [31:0] pre;
		logic [15:0]        act;
		logic               lst;
	} conv_result_t;

	// Scoreboard: holds its own copy of the engine state and the queue of
	// convolution results still owed by the block.
	class conv_scoreboard;
		shortint      weights [4][16][49];
		shortint      biases [16];
		shortint      lines [7*256];
		int unsigned  prow, pcol;
		int unsigned  regs [6];
		conv_result_t owed [$];
		int           errors;
		int           checked;

		function new();
			regs = '{28, 28, 3, 1, 1, 1};
			prow = 0;
			pcol = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(int idx, int unsigned val);
			int unsigned masks [6];
			masks = '{32'h1FF, 32'h1FF, 7, 7, 32'h1F, 7};
			regs[idx] = val & masks[idx];
		endfunction

		function int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		// Logistic function through exp(-|x|) built from a 2^(-k/16) table.
		function logic [15:0] logistic(logic signed [31:0] x);
			longint unsigned a, t, n, e, den, num, s;
			int unsigned kk, r, v, t0, t1;
			a = (x < 0) ? longint'(-longint'(x)) : longint'(x);
			t = (a * 94548) >> 16;
			n = t >> 16;
			kk = 32'((t >> 12) & 15);
			r = 32'(t & 12'hFFF);
			t0 = c2s_pkg::EXP2_TAB[kk];
			t1 = c2s_pkg::EXP2_TAB[kk+1];
			v = t0 - (((t0 - t1) * r) >> 12);
			e = (n >= 16) ? 0 : (v >> n);
			den = 65536 + e;
			num = (x >= 0) ? 64'h1_0000_0000 : (e << 16);
			s = (num + den / 2) / den;
			return (s > 65535) ? 16'hFFFF : s[15:0];
		endfunction

		// Note an accepted transfer and queue the results it causes.
		function void note_input(stream_item_t it);
			int unsigned wd, ht, k, s, nf, nc, row, col, r0, c0;
			longint acc, q;
			conv_result_t res;
			wd = clampu(regs[0], 1, 256);
			ht = clampu(regs[1], 1, 256);
			k  = clampu(regs[2], 1, 7);
			s  = clampu(regs[3], 1, 7);
			nf = clampu(regs[4], 1, 16);
			nc = clampu(regs[5], 1, 4);
			if (it.mode == c2s_pkg::MODE_WEIGHT) begin
				if (it.tap < 49)
					weights[it.ch][it.filt][it.tap] = it.smp;
				return;
			end
			if (it.mode == c2s_pkg::MODE_BIAS) begin
				biases[it.filt] = it.smp;
				return;
			end
			if (it.mode != c2s_pkg::MODE_PIXEL)
				return;
			row = prow;
			col = pcol;
			lines[(row % 7) * 256 + col] = it.smp;
			if (it.ch < nc && row + 1 >= k && col + 1 >= k) begin
				r0 = row + 1 - k;
				c0 = col + 1 - k;
				if (r0 % s == 0 && c0 % s == 0) begin
					for (int f = 0; f < nf; f++) begin
						acc = longint'(biases[f]) * 32768;
						for (int i = 0; i < k; i++)
							for (int j = 0; j < k; j++)
								acc += longint'(weights[it.ch][f][i*k+j]) *
									longint'(lines[((r0 + i) % 7) * 256 + c0 + j]);
						q = (acc + 8192) >>> 14;
						if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
						if (q < -64'sh8000_0000) q = -64'sh8000_0000;
						res.ch   = it.ch;
						res.filt = 4'(f);
						res.row  = 8'(r0 / s);
						res.col  = 8'(c0 / s);
						res.pre  = q[31:0];
						res.act  = logistic(q[31:0]);
						res.lst  = (f + 1 == nf);
						owed.push_back(res);
					end
				end
			end
			col++;
			if (col >= wd) begin
				col = 0;
				row++;
				if (row >= ht) row = 0;
			end
			prow = row;
			pcol = col;
		endfunction

		// Compare one result transfer with the oldest owed result.
		function void check_result(conv_result_t got);
			conv_result_t exp_r;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result ch=%0d filt=%0d row=%0d col=%0d",
					$realtime, got.ch, got.filt, got.row, got.col);
				errors++;
				return;
			end
			exp_r = owed.pop_front();
			checked++;
			if (got !== exp_r) begin
				$display({"%0t: mismatch expected ch=%0d filt=%0d row=%0d col=%0d",
					" pre=%0d act=%0d last=%0d"},
					$realtime, exp_r.ch, exp_r.filt, exp_r.row, exp_r.col, exp_r.pre,
					exp_r.act, exp_r.lst);
				$display({"%0t:          actual   ch=%0d filt=%0d row=%0d col=%0d",
					" pre=%0d act=%0d last=%0d"},
					$realtime, got.ch, got.filt, got.row, got.col, got.pre, got.act,
					got.lst);
				errors++;
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        psel, penable, pwrite;
	logic [c2s_pkg::PADDR_W-1:0] paddr;
	logic [31:0]                 pwdata;
	logic [31:0]                 prdata;
	logic                        pready;
	logic                        in_valid, in_ready;
	logic [1:0]                  mode, channel;
	logic [3:0]                  filter_index;
	logic [5:0]                  tap_index;
	logic signed [15:0]          sample;
	logic                        out_valid, out_ready;
	logic [1:0]                  out_channel;
	logic [3:0]                  out_filter;
	logic [7:0]                  out_row, out_col;
	logic signed [31:0]          pre_activation;
	logic [15:0]                 activated;
	logic                        last;

	conv_scoreboard sb = new();
	int             gap_pct;
	int             stall_pct;
	int             cycles = 0;
	int             pixels_sent;
	bit             weight_loaded [4][16][49];
	bit             bias_loaded [16];

	conv2d_sigmoid_engine_unit dut (.*);

	// Clock.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Cycle counter and watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result receiver with random stalls.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Check each result transfer.
	always @(posedge clk) begin
		conv_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.ch   = out_channel;
			got.filt = out_filter;
			got.row  = out_row;
			got.col  = out_col;
			got.pre  = pre_activation;
			got.act  = activated;
			got.lst  = last;
			sb.check_result(got);
		end
	end

	// APB register write: setup cycle, then access cycle.
	task automatic write_reg(logic [2:0] idx, int unsigned val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= c2s_pkg::PADDR_W'(idx) << 2;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	// Drive one stream transfer, with a random gap ahead of it.
	task automatic send(stream_item_t it);
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= it.mode;
		channel      <= it.ch;
		filter_index <= it.filt;
		tap_index    <= it.tap;
		sample       <= it.smp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(it);
		if (it.mode == c2s_pkg::MODE_WEIGHT && it.tap < 49)
			weight_loaded[it.ch][it.filt][it.tap] = 1'b1;
		if (it.mode == c2s_pkg::MODE_BIAS)
			bias_loaded[it.filt] = 1'b1;
		if (it.mode == c2s_pkg::MODE_PIXEL)
			pixels_sent++;
	endtask

	task automatic send_fields(logic [1:0] md, logic [1:0] ch, logic [3:0] fl,
			logic [5:0] tp, logic signed [15:0] sm);
		stream_item_t it;
		it.mode = md;
		it.ch   = ch;
		it.filt = fl;
		it.tap  = tp;
		it.smp  = sm;
		send(it);
	endtask

	// Wait until the block owes nothing, then let a pixel still in flight drain.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic program_regs(int unsigned w, int unsigned h, int unsigned k,
			int unsigned s, int unsigned nf, int unsigned nc);
		write_reg(c2s_pkg::REG_IMAGE_WIDTH, w);
		write_reg(c2s_pkg::REG_IMAGE_HEIGHT, h);
		write_reg(c2s_pkg::REG_KERNEL_SIZE, k);
		write_reg(c2s_pkg::REG_STEP_SIZE, s);
		write_reg(c2s_pkg::REG_FILTERS_IN_USE, nf);
		write_reg(c2s_pkg::REG_CHANNELS_IN_USE, nc);
	endtask

	// Load every weight and bias the current setting can read that is not loaded yet.
	task automatic load_missing();
		int unsigned k, nf, nc;
		k  = sb.clampu(sb.regs[2], 1, 7);
		nf = sb.clampu(sb.regs[4], 1, 16);
		nc = sb.clampu(sb.regs[5], 1, 4);
		for (int c = 0; c < nc; c++)
			for (int f = 0; f < nf; f++)
				for (int t = 0; t < k * k; t++)
					if (!weight_loaded[c][f][t])
						send_fields(c2s_pkg::MODE_WEIGHT, 2'(c), 4'(f), 6'(t),
							16'($urandom));
		for (int f = 0; f < nf; f++)
			if (!bias_loaded[f])
				send_fields(c2s_pkg::MODE_BIAS, 2'($urandom), 4'(f), 6'($urandom),
					16'($urandom));
	endtask

	// Random traffic: mostly pixels, whole planes, with reloads and noise mixed in.
	task automatic random_planes(int planes, bit pause_midway);
		int unsigned total, nc, sel;
		stream_item_t it;
		total = planes * sb.clampu(sb.regs[0], 1, 256) * sb.clampu(sb.regs[1], 1, 256);
		nc = sb.clampu(sb.regs[5], 1, 4);
		pixels_sent = 0;
		while (pixels_sent < total) begin
			if (pause_midway && pixels_sent == total / 2) begin
				in_valid <= 1'b0;
				while (sb.owed.size() != 0) @(posedge clk);
				@(posedge clk);
				pause_midway = 0;
			end
			sel = $urandom_range(99);
			it.ch   = 2'($urandom);
			it.filt = 4'($urandom);
			it.tap  = 6'($urandom);
			it.smp  = 16'($urandom);
			if (sel < 12) begin
				it.mode = c2s_pkg::MODE_WEIGHT;
			end else if (sel < 16) begin
				it.mode = c2s_pkg::MODE_BIAS;
			end else if (sel < 18) begin
				it.mode = 2'd3;
			end else begin
				it.mode = c2s_pkg::MODE_PIXEL;
				if ($urandom_range(9) < 8)
					it.ch = 2'($urandom_range(nc - 1));
				if ($urandom_range(9) == 0)
					it.smp = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			end
			send(it);
		end
	endtask

	// Setting table: width, height, kernel, stride, filters, channels, planes.
	int unsigned settings [8][7] = '{
		'{6, 5,  3, 1, 2,  2, 1},
		'{7, 7,  7, 7, 1,  1, 1},
		'{0, 0,  0, 0, 0,  7, 3},
		'{1, 16, 1, 3, 1,  1, 1},
		'{4, 2,  1, 1, 31, 1, 1},
		'{6, 6,  4, 2, 1,  3, 1},
		'{3, 3,  5, 1, 2,  1, 3},
		'{5, 4,  3, 2, 2,  4, 1}
	};

	int unsigned pair_gap [4]   = '{0, 47, 0, 27};
	int unsigned pair_stall [4] = '{0, 0, 47, 27};

	// Main sequence.
	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		mode         = '0;
		channel      = '0;
		filter_index = '0;
		tap_index    = '0;
		sample       = '0;
		gap_pct      = 0;
		stall_pct    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extreme weights, biases and pixels on a 4x3 image.
		program_regs(4, 3, 2, 1, 2, 1);
		for (int t = 0; t < 4; t++) begin
			send_fields(c2s_pkg::MODE_WEIGHT, 2'd0, 4'd0, 6'(t),
				t[0] ? 16'sh8000 : 16'sh7FFF);
			send_fields(c2s_pkg::MODE_WEIGHT, 2'd0, 4'd1, 6'(t),
				t[0] ? 16'sh7FFF : 16'sh8000);
		end
		send_fields(c2s_pkg::MODE_BIAS, 2'd3, 4'd0, 6'd63, 16'sh7FFF);
		send_fields(c2s_pkg::MODE_BIAS, 2'd0, 4'd1, 6'd0, 16'sh8000);
		// Out-of-range tap and an unused mode are both ignored.
		send_fields(c2s_pkg::MODE_WEIGHT, 2'd3, 4'd15, 6'd63, 16'sh5A5A);
		send_fields(2'd3, 2'd3, 4'd15, 6'd63, 16'sh7FFF);
		for (int p = 0; p < 12; p++) begin
			case (p % 4)
				0: send_fields(c2s_pkg::MODE_PIXEL, 2'd0, 4'd0, 6'd0, 16'sh7FFF);
				1: send_fields(c2s_pkg::MODE_PIXEL, 2'd0, 4'd0, 6'd0, 16'sh8000);
				2: send_fields(c2s_pkg::MODE_PIXEL, (p == 6) ? 2'd1 : 2'd0, 4'd0, 6'd0,
					16'sh0001);
				default: send_fields(c2s_pkg::MODE_PIXEL, (p == 7) ? 2'd3 : 2'd0, 4'd0,
					6'd0, 16'sh0000);
			endcase
		end
		drain();

		// Random phases over several settings and idling mixes.
		for (int ph = 0; ph < 8; ph++) begin
			gap_pct   = 0;
			stall_pct = 0;
			program_regs(settings[ph][0], settings[ph][1], settings[ph][2],
				settings[ph][3], settings[ph][4], settings[ph][5]);
			load_missing();
			gap_pct   = pair_gap[ph % 4];
			stall_pct = pair_stall[ph % 4];
			random_planes(settings[ph][6], ph == 3);
			drain();
		end

		$display("Covered weight and bias loads, ignored items and %0d convolution results",
			sb.checked);
		$display("over 9 register settings including clamped and extreme sizes.");
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
